// ===== rtl/lrc_pkg.sv =====
// ----------------------------------------------------------------------------
// lrc_pkg
// Shared types and constants of the lookahead row convolution core.
// ----------------------------------------------------------------------------
`default_nettype none

package lrc_pkg;

   localparam int SAMPLE_W    = 16;
   localparam int SUM_W       = 36;
   localparam int GROUP_W     = 6;
   localparam int TAP_W       = 3;
   localparam int ROWS_BACK_W = 3;
   localparam int CTX_W       = 4;
   localparam int LANE_SLOTS  = 4;

   localparam int LANES_DEF       = 4;
   localparam int GROUPS_DEF      = 64;
   localparam int MAX_CONTEXT_DEF = 8;

   localparam logic ACT_LOAD = 1'b0;
   localparam logic ACT_DATA = 1'b1;

   typedef struct packed {
      logic                       action;
      logic [GROUP_W-1:0]         group;
      logic [TAP_W-1:0]           tap;
      logic signed [SAMPLE_W-1:0] value0;
      logic signed [SAMPLE_W-1:0] value1;
      logic signed [SAMPLE_W-1:0] value2;
      logic signed [SAMPLE_W-1:0] value3;
      logic                       sequence_end;
   } req_type;

   typedef struct packed {
      logic [GROUP_W-1:0]      out_group;
      logic [ROWS_BACK_W-1:0]  rows_back;
      logic signed [SUM_W-1:0] sum0;
      logic signed [SUM_W-1:0] sum1;
      logic signed [SUM_W-1:0] sum2;
      logic signed [SUM_W-1:0] sum3;
      logic                    run_last;
   } rsp_type;

   // Header of one result, handed from the controller to the output stage.
   typedef struct packed {
      logic [GROUP_W-1:0]     out_group;
      logic [ROWS_BACK_W-1:0] rows_back;
      logic                   run_last;
   } hdr_type;

endpackage

`default_nettype wire

// ===== rtl/lrc_ram.sv =====
// ----------------------------------------------------------------------------
// lrc_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module lrc_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 512,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/lrc_lane.sv =====
// ----------------------------------------------------------------------------
// lrc_lane
// One channel lane: registered Q2.30 product and a Q6.30 accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module lrc_lane (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                clear,
   input  wire logic                                in_valid,
   input  wire logic signed [lrc_pkg::SAMPLE_W-1:0] sample,
   input  wire logic signed [lrc_pkg::SAMPLE_W-1:0] weight,
   output logic             [lrc_pkg::SUM_W-1:0]    sum
);

   import lrc_pkg::*;

   localparam int PROD_W = 2 * SAMPLE_W;

   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic                     prod_valid_ff, prod_valid_in;
   logic signed [SUM_W-1:0]  acc_ff, acc_in;

   always_comb begin
      prod_in       = PROD_W'(sample) * PROD_W'(weight);
      prod_valid_in = in_valid;
      priority if (clear) begin
         acc_in = '0;
      end else if (prod_valid_ff) begin
         acc_in = acc_ff + SUM_W'(prod_ff);
      end else begin
         acc_in = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
      end else begin
         prod_valid_ff <= prod_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign sum = acc_ff;

endmodule

`default_nettype wire

// ===== rtl/lrc_merge.sv =====
// ----------------------------------------------------------------------------
// lrc_merge
// Gathers the lane sums and the header into one result and holds it in the
// output register until the consumer takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module lrc_merge #(
   parameter int LANES = lrc_pkg::LANES_DEF
) (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   input  wire logic                                     load,
   input  wire lrc_pkg::hdr_type                         hdr,
   input  wire logic [LANES-1:0][lrc_pkg::SUM_W-1:0]     lane_sums,
   output logic                                          free,
   output logic                                          rsp_valid,
   input  wire logic                                     rsp_ready,
   output lrc_pkg::rsp_type                              rsp_data
);

   import lrc_pkg::*;

   logic [LANE_SLOTS-1:0][SUM_W-1:0] all_sums;
   logic                             rsp_valid_ff, rsp_valid_in;
   rsp_type                          rsp_data_ff, rsp_data_in;

   // Lanes that are not built read as zero.
   assign all_sums = (LANE_SLOTS * SUM_W)'(lane_sums);
   assign free     = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_data_in = rsp_data_ff;
      priority if (load) begin
         rsp_valid_in          = 1'b1;
         rsp_data_in.out_group = hdr.out_group;
         rsp_data_in.rows_back = hdr.rows_back;
         rsp_data_in.sum0      = all_sums[0];
         rsp_data_in.sum1      = all_sums[1];
         rsp_data_in.sum2      = all_sums[2];
         rsp_data_in.sum3      = all_sums[3];
         rsp_data_in.run_last  = hdr.run_last;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ===== rtl/lookahead_row_convolution_core.sv =====
// ----------------------------------------------------------------------------
// lookahead_row_convolution_core
// Forward lookahead row convolution over streamed groups of channel samples,
// with per-group history rings, a weight memory and parallel MAC lanes.
// ----------------------------------------------------------------------------
//  Channel   Ports                        Direction  Carries
//  req       req_valid/ready, req_data    in         weight load or data row
//  rsp       rsp_valid/ready, rsp_data    out        one output row of sums
//  csr       csr_valid/ready, csr_data    in         context length
//
//  A weight load is written straight into the weight memory. A data row
//  first updates its group state, then each output reads one tap per cycle
//  from the history and weight memories, drains the lane pipeline and is
//  handed to the output stage. Synchronous active-high reset clears the
//  control state only; the memories hold garbage until written. A stalled
//  result waits in the output register while the next request is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module lookahead_row_convolution_core #(
   parameter int LANES       = lrc_pkg::LANES_DEF,
   parameter int GROUPS      = lrc_pkg::GROUPS_DEF,
   parameter int MAX_CONTEXT = lrc_pkg::MAX_CONTEXT_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire lrc_pkg::req_type            req_data,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output lrc_pkg::rsp_type                 rsp_data,
   input  wire logic                        csr_valid,
   output logic                             csr_ready,
   input  wire logic [lrc_pkg::CTX_W-1:0]   csr_data
);

   import lrc_pkg::*;

   localparam int GIW   = (GROUPS > 1) ? $clog2(GROUPS) : 1;
   localparam int TW    = (MAX_CONTEXT > 1) ? $clog2(MAX_CONTEXT) : 1;
   localparam int CW    = $clog2(MAX_CONTEXT + 1);
   localparam int MW    = CW + TW;
   localparam int ROW_W = LANES * SAMPLE_W;
   localparam int DEPTH = GROUPS * MAX_CONTEXT;
   localparam int HAW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_META  = 3'd1;
   localparam logic [2:0] S_MAC   = 3'd2;
   localparam logic [2:0] S_DRAIN = 3'd3;
   localparam logic [2:0] S_OUT   = 3'd4;

   logic [2:0]        state_ff, state_in;
   logic [CTX_W-1:0]  ctx_ff, ctx_in;
   logic [GROUPS-1:0] seen_vld_ff, seen_vld_in;
   logic [GIW-1:0]    g_ff, g_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic              flush_ff, flush_in;
   logic [TW-1:0]     head_ff, head_in;
   logic [TW-1:0]     r_ff, r_in;
   logic [TW-1:0]     w_ff, w_in;
   logic              rd_valid_ff, rd_last_ff, prod_last_ff;

   logic                                 req_accept;
   logic                                 req_in_range, tap_in_range;
   logic [GIW-1:0]                       req_gidx;
   logic [LANE_SLOTS-1:0][SAMPLE_W-1:0]  req_vals;
   logic [ROW_W-1:0]                     req_row;

   logic             wt_wr_en;
   logic [HAW-1:0]   wt_wr_addr, wt_rd_addr;
   logic [ROW_W-1:0] wt_rd_data;
   logic             hist_wr_en;
   logic [HAW-1:0]   hist_wr_addr, hist_rd_addr;
   logic [ROW_W-1:0] hist_rd_data;
   logic             st_wr_en;
   logic [MW-1:0]    st_wr_data, st_rd_data;

   logic [CW-1:0]   ctx_eff, n_old, n_new, m_cnt;
   logic [TW-1:0]   head_old, head_new, back, slot;
   logic [TW:0]     slot_wrap;
   logic            issue, issue_last, acc_clear, out_load, out_free, emit_last;
   hdr_type         out_hdr;
   logic [LANES-1:0][SUM_W-1:0] lane_sums;

   // ---- request decode ----
   assign req_ready    = (state_ff == S_IDLE);
   assign req_accept   = req_valid && req_ready;
   assign req_in_range = (32'(req_data.group) < GROUPS);
   assign tap_in_range = (32'(req_data.tap) < MAX_CONTEXT);
   assign req_gidx     = GIW'(req_data.group);
   assign req_vals     = {req_data.value3, req_data.value2, req_data.value1, req_data.value0};
   assign req_row      = ROW_W'(req_vals);

   assign csr_ready = 1'b1;

   // Weight loads are written straight from the request port.
   assign wt_wr_en   = req_accept && (req_data.action == ACT_LOAD)
                       && req_in_range && tap_in_range;
   assign wt_wr_addr = HAW'(req_data.tap) * HAW'(GROUPS) + HAW'(req_gidx);
   assign wt_rd_addr = HAW'(w_ff) * HAW'(GROUPS) + HAW'(g_ff);

   // ---- context length and group state ----
   always_comb begin
      priority if (ctx_ff == '0) begin
         ctx_eff = CW'(1);
      end else if (32'(ctx_ff) > MAX_CONTEXT) begin
         ctx_eff = CW'(MAX_CONTEXT);
      end else begin
         ctx_eff = CW'(ctx_ff);
      end
   end

   // A group never written since reset starts with no rows and the ring at zero.
   assign n_old    = seen_vld_ff[g_ff] ? st_rd_data[MW-1:TW] : '0;
   assign head_old = seen_vld_ff[g_ff] ? st_rd_data[TW-1:0] : '0;
   assign n_new    = (32'(n_old) == MAX_CONTEXT) ? n_old : n_old + CW'(1);
   assign head_new = (32'(head_old) == MAX_CONTEXT - 1) ? '0 : head_old + TW'(1);
   assign m_cnt    = (n_new < ctx_eff) ? n_new : ctx_eff;
   assign st_wr_data = {(flush_ff ? CW'(0) : n_new), head_new};

   assign hist_wr_addr = HAW'(g_ff) * HAW'(MAX_CONTEXT) + HAW'(head_new);

   // The row that lies back rows before the newest one sits that far behind
   // the ring head.
   assign back      = r_ff - w_ff;
   assign slot_wrap = (TW + 1)'(head_ff) + (TW + 1)'(MAX_CONTEXT) - (TW + 1)'(back);
   assign slot      = (head_ff >= back) ? head_ff - back : TW'(slot_wrap);
   assign hist_rd_addr = HAW'(g_ff) * HAW'(MAX_CONTEXT) + HAW'(slot);

   assign emit_last = !flush_ff || (r_ff == '0);

   // ---- controller ----
   always_comb begin
      state_in    = state_ff;
      ctx_in      = ctx_ff;
      seen_vld_in = seen_vld_ff;
      g_in        = g_ff;
      row_in      = row_ff;
      flush_in    = flush_ff;
      head_in     = head_ff;
      r_in        = r_ff;
      w_in        = w_ff;
      hist_wr_en  = 1'b0;
      st_wr_en    = 1'b0;
      issue       = 1'b0;
      issue_last  = 1'b0;
      out_load    = 1'b0;

      if (csr_valid) begin
         ctx_in = csr_data;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept && (req_data.action == ACT_DATA) && req_in_range) begin
               g_in     = req_gidx;
               row_in   = req_row;
               flush_in = req_data.sequence_end;
               state_in = S_META;
            end
         end
         S_META: begin
            hist_wr_en = 1'b1;
            st_wr_en   = 1'b1;
            seen_vld_in[g_ff] = 1'b1;
            head_in    = head_new;
            w_in       = '0;
            priority if (flush_ff) begin
               r_in     = TW'(m_cnt - CW'(1));
               state_in = S_MAC;
            end else if (n_new >= ctx_eff) begin
               r_in     = TW'(ctx_eff - CW'(1));
               state_in = S_MAC;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_MAC: begin
            issue = 1'b1;
            w_in  = w_ff + TW'(1);
            if (w_ff == r_ff) begin
               issue_last = 1'b1;
               state_in   = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (prod_last_ff) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (out_free) begin
               out_load = 1'b1;
               if (emit_last) begin
                  state_in = S_IDLE;
               end else begin
                  r_in     = r_ff - TW'(1);
                  w_in     = '0;
                  state_in = S_MAC;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign acc_clear = (state_ff == S_META) || out_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ctx_ff       <= CTX_W'(1);
         seen_vld_ff  <= '0;
         rd_valid_ff  <= 1'b0;
         rd_last_ff   <= 1'b0;
         prod_last_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ctx_ff       <= ctx_in;
         seen_vld_ff  <= seen_vld_in;
         rd_valid_ff  <= issue;
         rd_last_ff   <= issue_last;
         prod_last_ff <= rd_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      g_ff     <= g_in;
      row_ff   <= row_in;
      flush_ff <= flush_in;
      head_ff  <= head_in;
      r_ff     <= r_in;
      w_ff     <= w_in;
   end

   // ---- memories ----
   lrc_ram #(.WIDTH(ROW_W), .DEPTH(DEPTH)) u_weight_ram (
      .clock   (clock),
      .wr_en   (wt_wr_en),
      .wr_addr (wt_wr_addr),
      .wr_data (req_row),
      .rd_en   (issue),
      .rd_addr (wt_rd_addr),
      .rd_data (wt_rd_data)
   );

   lrc_ram #(.WIDTH(ROW_W), .DEPTH(DEPTH)) u_history_ram (
      .clock   (clock),
      .wr_en   (hist_wr_en),
      .wr_addr (hist_wr_addr),
      .wr_data (row_ff),
      .rd_en   (issue),
      .rd_addr (hist_rd_addr),
      .rd_data (hist_rd_data)
   );

   lrc_ram #(.WIDTH(MW), .DEPTH(GROUPS)) u_state_ram (
      .clock   (clock),
      .wr_en   (st_wr_en),
      .wr_addr (g_ff),
      .wr_data (st_wr_data),
      .rd_en   (req_accept),
      .rd_addr (req_gidx),
      .rd_data (st_rd_data)
   );

   // ---- lanes ----
   for (genvar i = 0; i < LANES; i++) begin : g_lane
      lrc_lane u_lane (
         .clock    (clock),
         .reset    (reset),
         .clear    (acc_clear),
         .in_valid (rd_valid_ff),
         .sample   (hist_rd_data[i*SAMPLE_W +: SAMPLE_W]),
         .weight   (wt_rd_data[i*SAMPLE_W +: SAMPLE_W]),
         .sum      (lane_sums[i])
      );
   end

   // ---- output stage ----
   always_comb begin
      out_hdr.out_group = GROUP_W'(g_ff);
      out_hdr.rows_back = ROWS_BACK_W'(r_ff);
      out_hdr.run_last  = emit_last;
   end

   lrc_merge #(.LANES(LANES)) u_merge (
      .clock     (clock),
      .reset     (reset),
      .load      (out_load),
      .hdr       (out_hdr),
      .lane_sums (lane_sums),
      .free      (out_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for lookahead_row_convolution_core. Weight loads and
// data rows are streamed in over the request channel with random gaps, and
// results are drained with random stalls. A scoreboard class keeps its own
// copy of the history rings, the weights and the row counters, predicts every
// output row exactly, and compares the results in order. The context length
// is rewritten between phases, the extreme values included.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
   import lrc_pkg::*;

   localparam int NUM_GROUPS = GROUPS_DEF;
   localparam int NUM_TAPS   = MAX_CONTEXT_DEF;
   localparam int SETTLE_CYCLES = 100;

   class row_sum_board;
      bit [63:0]   history [NUM_GROUPS*NUM_TAPS];
      bit [63:0]   weights [NUM_TAPS*NUM_GROUPS];
      int unsigned seen [NUM_GROUPS];
      int unsigned taps_cfg;
      rsp_type     expected_rows [$];
      int          errors;

      function new();
         foreach (history[i]) history[i] = '0;
         foreach (weights[i]) weights[i] = '0;
         foreach (seen[i]) seen[i] = 0;
         taps_cfg = 1;
         errors = 0;
      endfunction

      function void set_context(logic [CTX_W-1:0] v);
         if (v == 0) taps_cfg = 1;
         else if (v > NUM_TAPS) taps_cfg = NUM_TAPS;
         else taps_cfg = 32'(v);
      endfunction

      function longint lane_value(bit [63:0] w, int lane);
         return longint'($signed(w[16*lane +: 16]));
      endfunction

      // Output row r back from the newest row of group g, over taps 0..taps-1.
      function void add_row(int g, int r, int taps, bit last);
         rsp_type e;
         longint  acc [4];
         for (int lane = 0; lane < 4; lane++) begin
            acc[lane] = 0;
            for (int w = 0; w < taps; w++)
               acc[lane] += lane_value(history[g*NUM_TAPS + r - w], lane) *
                            lane_value(weights[w*NUM_GROUPS + g], lane);
         end
         e.out_group = g[GROUP_W-1:0];
         e.rows_back = r[ROWS_BACK_W-1:0];
         e.sum0 = acc[0][SUM_W-1:0];
         e.sum1 = acc[1][SUM_W-1:0];
         e.sum2 = acc[2][SUM_W-1:0];
         e.sum3 = acc[3][SUM_W-1:0];
         e.run_last = last;
         expected_rows.push_back(e);
      endfunction

      function void take_request(req_type q);
         int unsigned g;
         int unsigned n;
         int unsigned m;
         bit [63:0]   word;
         g = 32'(q.group);
         word = {q.value3, q.value2, q.value1, q.value0};
         if (q.action == ACT_LOAD) begin
            weights[q.tap*NUM_GROUPS + g] = word;
            return;
         end
         for (int j = NUM_TAPS - 1; j > 0; j--)
            history[g*NUM_TAPS + j] = history[g*NUM_TAPS + j - 1];
         history[g*NUM_TAPS] = word;
         n = seen[g];
         if (n < NUM_TAPS) n++;
         seen[g] = n;
         if (!q.sequence_end) begin
            if (n >= taps_cfg) add_row(g, taps_cfg - 1, taps_cfg, 1'b1);
         end else begin
            // Sequence end: flush the pending rows oldest first, each with
            // only as many taps as there are rows from it to the newest.
            m = (n < taps_cfg) ? n : taps_cfg;
            while (m > 0) begin
               add_row(g, m - 1, m, m == 1);
               m--;
            end
            seen[g] = 0;
         end
      endfunction

      task report(string what);
         $display("ERROR: %s", what);
         errors++;
      endtask

      task check_field(string name, logic [SUM_W-1:0] got, logic [SUM_W-1:0] want);
         if (got !== want)
            report($sformatf("%s got %h expected %h", name, got, want));
      endtask

      task check_row(rsp_type got);
         rsp_type want;
         if (expected_rows.size() == 0) begin
            report($sformatf("unexpected result group %0d rows_back %0d",
                             got.out_group, got.rows_back));
            return;
         end
         want = expected_rows.pop_front();
         check_field("out_group", SUM_W'(got.out_group), SUM_W'(want.out_group));
         check_field("rows_back", SUM_W'(got.rows_back), SUM_W'(want.rows_back));
         check_field("sum0", got.sum0, want.sum0);
         check_field("sum1", got.sum1, want.sum1);
         check_field("sum2", got.sum2, want.sum2);
         check_field("sum3", got.sum3, want.sum3);
         check_field("run_last", SUM_W'(got.run_last), SUM_W'(want.run_last));
      endtask
   endclass

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   req_type          req_data = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   rsp_type          rsp_data;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [CTX_W-1:0] csr_data = '0;

   row_sum_board sums = new();
   bit           quiet = 1'b0;
   int           stall_left = 0;
   int unsigned  active_taps = 1;
   bit           weight_loaded [NUM_TAPS][NUM_GROUPS];

   lookahead_row_convolution_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) sums.take_request(req_data);
         if (rsp_valid && rsp_ready) sums.check_row(rsp_data);
      end
   end

   // Result side: stall in random bursts until the quiet stretch at the end.
   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left = stall_left - 1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
         rsp_ready <= 1'b0;
         stall_left = $urandom_range(1, 10) - 1;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   function automatic logic [SAMPLE_W-1:0] random_sample();
      case ($urandom_range(0, 7))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0000;
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   function automatic bit [63:0] random_word();
      return {random_sample(), random_sample(), random_sample(), random_sample()};
   endfunction

   function automatic int pick_group();
      if ($urandom_range(0, 7) == 0) return $urandom_range(0, NUM_GROUPS - 1);
      return $urandom_range(0, 3);
   endfunction

   task send_request(req_type q);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= q;
      do @(posedge clock); while (!req_ready);
   endtask

   task send_load(int g, int t, bit [63:0] w, bit se);
      req_type q;
      q.action = ACT_LOAD;
      q.group = GROUP_W'(g);
      q.tap = TAP_W'(t);
      {q.value3, q.value2, q.value1, q.value0} = w;
      q.sequence_end = se;
      weight_loaded[t][g] = 1'b1;
      send_request(q);
   endtask

   // Every tap a data row can reach must hold a loaded weight first.
   task send_data(int g, bit [63:0] row, bit se);
      req_type q;
      for (int t = 0; t < active_taps; t++)
         if (!weight_loaded[t][g])
            send_load(g, t, random_word(), 1'($urandom_range(0, 1)));
      q.action = ACT_DATA;
      q.group = GROUP_W'(g);
      q.tap = TAP_W'($urandom);
      {q.value3, q.value2, q.value1, q.value0} = row;
      q.sequence_end = se;
      send_request(q);
   endtask

   // Let all expected results arrive, then give any silent work time to end.
   task settle();
      req_valid <= 1'b0;
      while (sums.expected_rows.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task write_context(logic [CTX_W-1:0] v);
      csr_valid <= 1'b1;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sums.set_context(v);
      active_taps = sums.taps_cfg;
   endtask

   task random_phase(int count, bit quiet_tail);
      for (int i = 0; i < count; i++) begin
         if (quiet_tail && i == count / 2) quiet = 1'b1;
         if ($urandom_range(0, 6) == 0)
            send_load(pick_group(), $urandom_range(0, NUM_TAPS - 1), random_word(),
                      1'($urandom_range(0, 1)));
         else
            send_data(pick_group(), random_word(), $urandom_range(0, 5) == 0);
      end
   endtask

   initial begin
      logic [CTX_W-1:0] settings [8];
      settings = '{4'd3, 4'd8, 4'd1, 4'd15, 4'd0, 4'd5, 4'd9, 4'd2};
      foreach (weight_loaded[t, g]) weight_loaded[t][g] = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Context length at its reset value of one.
      send_load(63, 0, {4{16'h8000}}, 1'b0);
      send_load(63, 7, {4{16'h7FFF}}, 1'b1);
      send_data(63, {4{16'h8000}}, 1'b0);
      send_data(63, {16'h7FFF, 16'h8000, 16'h7FFF, 16'h0000}, 1'b1);
      settle();
      // A zero length acts as one.
      write_context(4'd0);
      send_load(0, 0, {16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000}, 1'b0);
      send_data(0, {4{16'h7FFF}}, 1'b0);
      settle();
      // An oversized length saturates; the open sequence of group 0 carries
      // over the change and ends in a full flush.
      write_context(4'd15);
      for (int t = 1; t < NUM_TAPS; t++)
         send_load(0, t, (t % 2) ? {4{16'h8000}} : {4{16'h7FFF}}, 1'b0);
      for (int k = 0; k < 8; k++)
         send_data(0, (k % 2) ? {4{16'h8000}} : {4{16'h7FFF}}, k == 7);
      settle();

      // Weight loads for newly reached taps come on top of each phase.
      foreach (settings[p]) begin
         write_context(settings[p]);
         random_phase(32, p == 7);
         settle();
      end

      if (sums.errors == 0)
         $display("lookahead_row_convolution_core: match");
      else
         $display("lookahead_row_convolution_core: mismatch");
      $finish;
   end

   initial begin
      #30000000;
      $display("lookahead_row_convolution_core: mismatch");
      $finish;
   end

endmodule

`default_nettype wire

// ===== lookahead_row_convolution_core.f =====
rtl/lrc_pkg.sv
rtl/lrc_ram.sv
rtl/lrc_lane.sv
rtl/lrc_merge.sv
rtl/lookahead_row_convolution_core.sv
sim/tb.sv
